### rtl/apts_pkg.sv
// apts_pkg: shared types and constants of the aging priority task scheduler
`timescale 1ns / 1ps

package apts_pkg;

  localparam logic [15:0] NEW_TASK_PRIO = 16'd2;
  localparam logic [15:0] PRIO_MAX      = 16'hFFFF;
  localparam logic [15:0] SLOT0_PRIO    = 16'd1;

  typedef enum logic [2:0] {
    ACT_SCHEDULE   = 3'd0,
    ACT_CREATE     = 3'd1,
    ACT_KILL       = 3'd2,
    ACT_EXIT       = 3'd3,
    ACT_SET_PRIO   = 3'd4,
    ACT_READ_COUNT = 3'd5,
    ACT_READ_ID    = 3'd6
  } action_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_AGE,
    ST_CLEAR,
    ST_KSCAN,
    ST_SHIFT,
    ST_RDCAP,
    ST_RUNRD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_AGE,
    SCAN_KILL,
    SCAN_SHIFT
  } scan_e;

  typedef enum logic [1:0] {
    PTR_ZERO,
    PTR_ONE,
    PTR_RUN_NEXT,
    PTR_MATCH_NEXT
  } ptr_sel_e;

  typedef struct packed {
    logic     latch_req;
    logic     init_wr;
    logic     ptr_load;
    ptr_sel_e ptr_sel;
    scan_e    scan;
    logic     create_wr;
    logic     setp_wr;
    logic     clear_best;
    logic     read_idx;
    logic     read_run;
    logic     cap_rid;
    logic     set_ok;
    logic     shrink;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    cnt_zero;
    logic    cnt_full;
    logic    run_live;
    logic    idx_live;
    logic    scan_done;
    logic    match;
    logic    out_free;
  } status_t;

endpackage

### rtl/apts_if.sv
// apts_if: request and response channel interfaces of the task scheduler
`timescale 1ns / 1ps

interface apts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] task_id;
  logic [15:0] new_priority;
  logic [5:0]  slot_index;

  modport source (output valid, output action, output task_id, output new_priority,
                  output slot_index, input ready);
  modport sink (input valid, input action, input task_id, input new_priority,
                input slot_index, output ready);
endinterface

interface apts_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [5:0]  running_slot;
  logic [15:0] running_id;
  logic        switched;
  logic [6:0]  task_count;
  logic [15:0] read_id;

  modport source (output valid, output ok, output running_slot, output running_id,
                  output switched, output task_count, output read_id, input ready);
  modport sink (input valid, input ok, input running_slot, input running_id,
                input switched, input task_count, input read_id, output ready);
endinterface

### rtl/apts_ctrl.sv
// apts_ctrl: sequencing state machine of the task scheduler
`timescale 1ns / 1ps

module apts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  apts_pkg::status_t status_i,
  output apts_pkg::cmd_t    cmd_o
);

  apts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apts_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      apts_pkg::ST_INIT: state_d = apts_pkg::ST_IDLE;
      apts_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = apts_pkg::ST_DECODE;
      end
      apts_pkg::ST_DECODE: begin
        case (status_i.action)
          apts_pkg::ACT_SCHEDULE: begin
            state_d = status_i.cnt_zero ? apts_pkg::ST_RUNRD : apts_pkg::ST_AGE;
          end
          apts_pkg::ACT_KILL: state_d = apts_pkg::ST_KSCAN;
          apts_pkg::ACT_EXIT: begin
            state_d = status_i.run_live ? apts_pkg::ST_SHIFT : apts_pkg::ST_RUNRD;
          end
          apts_pkg::ACT_READ_ID: begin
            state_d = status_i.idx_live ? apts_pkg::ST_RDCAP : apts_pkg::ST_RUNRD;
          end
          default: state_d = apts_pkg::ST_RUNRD;
        endcase
      end
      apts_pkg::ST_AGE: begin
        if (status_i.scan_done) state_d = apts_pkg::ST_CLEAR;
      end
      apts_pkg::ST_CLEAR: state_d = apts_pkg::ST_RUNRD;
      apts_pkg::ST_KSCAN: begin
        if (status_i.match) begin
          state_d = apts_pkg::ST_SHIFT;
        end else if (status_i.scan_done) begin
          state_d = apts_pkg::ST_RUNRD;
        end
      end
      apts_pkg::ST_SHIFT: begin
        if (status_i.scan_done) state_d = apts_pkg::ST_RUNRD;
      end
      apts_pkg::ST_RDCAP: state_d = apts_pkg::ST_RUNRD;
      apts_pkg::ST_RUNRD: state_d = apts_pkg::ST_OUT;
      apts_pkg::ST_OUT: begin
        if (status_i.out_free) state_d = apts_pkg::ST_IDLE;
      end
      default: state_d = apts_pkg::ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.ptr_sel = apts_pkg::PTR_ZERO;
    cmd_o.scan    = apts_pkg::SCAN_NONE;
    req_ready_o   = 1'b0;
    case (state_q)
      apts_pkg::ST_INIT: cmd_o.init_wr = 1'b1;
      apts_pkg::ST_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.latch_req = req_valid_i;
      end
      apts_pkg::ST_DECODE: begin
        case (status_i.action)
          apts_pkg::ACT_SCHEDULE: begin
            cmd_o.ptr_load = !status_i.cnt_zero;
            cmd_o.ptr_sel  = apts_pkg::PTR_ZERO;
          end
          apts_pkg::ACT_CREATE: begin
            cmd_o.create_wr = !status_i.cnt_full;
            cmd_o.set_ok    = !status_i.cnt_full;
          end
          apts_pkg::ACT_KILL: begin
            cmd_o.ptr_load = 1'b1;
            cmd_o.ptr_sel  = apts_pkg::PTR_ONE;
          end
          apts_pkg::ACT_EXIT: begin
            cmd_o.ptr_load = status_i.run_live;
            cmd_o.ptr_sel  = apts_pkg::PTR_RUN_NEXT;
            cmd_o.set_ok   = status_i.run_live;
          end
          apts_pkg::ACT_SET_PRIO: begin
            cmd_o.setp_wr = status_i.run_live;
            cmd_o.set_ok  = status_i.run_live;
          end
          apts_pkg::ACT_READ_COUNT: cmd_o.set_ok = 1'b1;
          apts_pkg::ACT_READ_ID: begin
            cmd_o.read_idx = status_i.idx_live;
            cmd_o.set_ok   = status_i.idx_live;
          end
          default: ;
        endcase
      end
      apts_pkg::ST_AGE: cmd_o.scan = apts_pkg::SCAN_AGE;
      apts_pkg::ST_CLEAR: cmd_o.clear_best = 1'b1;
      apts_pkg::ST_KSCAN: begin
        cmd_o.scan = apts_pkg::SCAN_KILL;
        if (status_i.match) begin
          cmd_o.set_ok   = 1'b1;
          cmd_o.ptr_load = 1'b1;
          cmd_o.ptr_sel  = apts_pkg::PTR_MATCH_NEXT;
        end
      end
      apts_pkg::ST_SHIFT: begin
        cmd_o.scan   = apts_pkg::SCAN_SHIFT;
        cmd_o.shrink = status_i.scan_done;
      end
      apts_pkg::ST_RDCAP: cmd_o.cap_rid = 1'b1;
      apts_pkg::ST_RUNRD: cmd_o.read_run = 1'b1;
      apts_pkg::ST_OUT: cmd_o.load_out = status_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/apts_datapath.sv
// apts_datapath: task tables, scan pointers and response register of the scheduler
`timescale 1ns / 1ps

module apts_datapath #(
  parameter int unsigned MAX_TASKS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        req_action_i,
  input  logic [15:0]       req_task_id_i,
  input  logic [15:0]       req_new_priority_i,
  input  logic [5:0]        req_slot_index_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output logic              rsp_ok_o,
  output logic [5:0]        rsp_running_slot_o,
  output logic [15:0]       rsp_running_id_o,
  output logic              rsp_switched_o,
  output logic [6:0]        rsp_task_count_o,
  output logic [15:0]       rsp_read_id_o,
  input  apts_pkg::cmd_t    cmd_i,
  output apts_pkg::status_t status_o
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  logic [15:0] prio_mem [MAX_TASKS];
  logic [15:0] id_mem [MAX_TASKS];
  logic [15:0] prio_rd_q, id_rd_q;

  apts_pkg::action_e action_q;
  logic [15:0]       task_q, newp_q;
  logic [5:0]        idx_q;

  logic [CW-1:0] count_q, ptr_q, wptr_q;
  logic [IW-1:0] run_q, bidx_q;
  logic [15:0]   last_q, best_q;
  logic          pv_q, ok_q, sw_q, rsp_valid_q;
  logic [15:0]   rid_q;

  logic          issue, run_live, age_better;
  logic [15:0]   prio_inc;
  logic [31:0]   idx_wide, run_wide, count_wide;
  logic [IW-1:0] idx_addr, ptr_addr, wptr_addr, count_addr;

  logic          prio_we, prio_re, id_we, id_re;
  logic [IW-1:0] prio_waddr, id_waddr, id_raddr;
  logic [15:0]   prio_wdata, id_wdata;

  assign idx_wide   = 32'(idx_q);
  assign run_wide   = 32'(run_q);
  assign count_wide = 32'(count_q);
  assign idx_addr   = idx_wide[IW-1:0];
  assign ptr_addr   = ptr_q[IW-1:0];
  assign wptr_addr  = wptr_q[IW-1:0];
  assign count_addr = count_q[IW-1:0];

  assign issue      = ptr_q < count_q;
  assign run_live   = CW'(run_q) < count_q;
  assign prio_inc   = (prio_rd_q == apts_pkg::PRIO_MAX) ? prio_rd_q : prio_rd_q + 16'd1;
  // slot 0 always opens the running maximum, later slots must beat it strictly
  assign age_better = (wptr_q == '0) || (prio_rd_q > best_q);

  always_comb begin
    status_o.action    = action_q;
    status_o.cnt_zero  = count_q == '0;
    status_o.cnt_full  = count_q >= CW'(MAX_TASKS);
    status_o.run_live  = run_live;
    status_o.idx_live  = idx_wide < count_wide;
    status_o.scan_done = !issue && !pv_q;
    status_o.match     = pv_q && (id_rd_q == task_q);
    status_o.out_free  = !rsp_valid_q || rsp_ready_i;
  end

  // priority table write port
  always_comb begin
    prio_we    = 1'b1;
    prio_waddr = wptr_addr;
    prio_wdata = prio_rd_q;
    if (cmd_i.init_wr) begin
      prio_waddr = '0;
      prio_wdata = apts_pkg::SLOT0_PRIO;
    end else if (cmd_i.create_wr) begin
      prio_waddr = count_addr;
      prio_wdata = apts_pkg::NEW_TASK_PRIO;
    end else if (cmd_i.setp_wr) begin
      prio_waddr = run_q;
      prio_wdata = newp_q;
    end else if (cmd_i.clear_best) begin
      prio_waddr = bidx_q;
      prio_wdata = '0;
    end else if (cmd_i.scan == apts_pkg::SCAN_AGE && pv_q) begin
      prio_wdata = prio_inc;
    end else if (cmd_i.scan == apts_pkg::SCAN_SHIFT && pv_q) begin
      prio_wdata = prio_rd_q;
    end else begin
      prio_we = 1'b0;
    end
  end

  // id table write port
  always_comb begin
    id_we    = 1'b1;
    id_waddr = wptr_addr;
    id_wdata = id_rd_q;
    if (cmd_i.init_wr) begin
      id_waddr = '0;
      id_wdata = '0;
    end else if (cmd_i.create_wr) begin
      id_waddr = count_addr;
      id_wdata = last_q + 16'd1;
    end else if (!(cmd_i.scan == apts_pkg::SCAN_SHIFT && pv_q)) begin
      id_we = 1'b0;
    end
  end

  assign prio_re = (cmd_i.scan == apts_pkg::SCAN_AGE || cmd_i.scan == apts_pkg::SCAN_SHIFT)
                   && issue;

  always_comb begin
    id_raddr = ptr_addr;
    id_re    = (cmd_i.scan == apts_pkg::SCAN_KILL || cmd_i.scan == apts_pkg::SCAN_SHIFT)
               && issue;
    if (cmd_i.read_idx) begin
      id_raddr = idx_addr;
      id_re    = 1'b1;
    end else if (cmd_i.read_run) begin
      id_raddr = run_q;
      id_re    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prio_we) prio_mem[prio_waddr] <= prio_wdata;
    if (prio_re) prio_rd_q <= prio_mem[ptr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (id_we) id_mem[id_waddr] <= id_wdata;
    if (id_re) id_rd_q <= id_mem[id_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CW'(1);
      run_q       <= '0;
      last_q      <= '0;
      ptr_q       <= '0;
      wptr_q      <= '0;
      pv_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ptr_load) begin
        pv_q <= 1'b0;
        case (cmd_i.ptr_sel)
          apts_pkg::PTR_ZERO:       ptr_q <= '0;
          apts_pkg::PTR_ONE:        ptr_q <= CW'(1);
          apts_pkg::PTR_RUN_NEXT:   ptr_q <= CW'(run_q) + CW'(1);
          apts_pkg::PTR_MATCH_NEXT: ptr_q <= wptr_q + CW'(1);
          default:                  ptr_q <= '0;
        endcase
      end else if (cmd_i.scan != apts_pkg::SCAN_NONE && issue) begin
        ptr_q  <= ptr_q + CW'(1);
        pv_q   <= 1'b1;
        // a shift reads slot i+1 and writes it back into slot i
        wptr_q <= (cmd_i.scan == apts_pkg::SCAN_SHIFT) ? ptr_q - CW'(1) : ptr_q;
      end else begin
        pv_q <= 1'b0;
      end

      if (cmd_i.create_wr) begin
        count_q <= count_q + CW'(1);
        last_q  <= last_q + 16'd1;
      end else if (cmd_i.shrink) begin
        count_q <= count_q - CW'(1);
        run_q   <= '0;
      end else if (cmd_i.clear_best) begin
        run_q <= bidx_q;
      end

      if (cmd_i.load_out) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      action_q <= apts_pkg::action_e'(req_action_i);
      task_q   <= req_task_id_i;
      newp_q   <= req_new_priority_i;
      idx_q    <= req_slot_index_i;
      ok_q     <= 1'b0;
      sw_q     <= 1'b0;
      rid_q    <= '0;
    end
    if (cmd_i.set_ok) ok_q <= 1'b1;
    if (cmd_i.clear_best) begin
      ok_q <= 1'b1;
      sw_q <= bidx_q != '0;
    end
    if (cmd_i.cap_rid) rid_q <= id_rd_q;
    if (cmd_i.scan == apts_pkg::SCAN_AGE && pv_q && age_better) begin
      best_q <= prio_rd_q;
      bidx_q <= wptr_addr;
    end
    if (cmd_i.load_out) begin
      rsp_ok_o           <= ok_q;
      rsp_running_slot_o <= run_wide[5:0];
      rsp_running_id_o   <= run_live ? id_rd_q : 16'd0;
      rsp_switched_o     <= sw_q;
      rsp_task_count_o   <= count_wide[6:0];
      rsp_read_id_o      <= rid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

### rtl/aging_priority_task_scheduler.sv
// Aging priority task scheduler: top level joining controller and datapath
//
// Usage:
//   req_i carries one request (action, task_id, new_priority, slot_index);
//   it is taken when valid and ready are both high. rsp_o returns exactly one
//   result per request, in order, holding it until ready is seen.
//   One request is worked on at a time; ready is high only while idle.
//   Work done per request:
//     schedule  one pass over the priority table (read, age, write back)
//     kill      id scan up to the match, then compaction above it
//     exit      compaction above the running slot
//   The table walks are bound by the single read and write port of each
//   table memory, one slot per cycle.
//   A finished result waits in the response register while the next request
//   is taken; if the receiver stalls, the next result waits for the register.
//   Reset: one cycle after reset release slot 0 is written with its reset
//   contents (priority 1, id 0); requests are taken from then on.
`timescale 1ns / 1ps

module aging_priority_task_scheduler #(
  parameter int unsigned MAX_TASKS = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  apts_req_if.sink   req_i,
  apts_rsp_if.source rsp_o
);

  apts_pkg::cmd_t    cmd;
  apts_pkg::status_t status;

  apts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  apts_datapath #(
    .MAX_TASKS(MAX_TASKS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_action_i      (req_i.action),
    .req_task_id_i     (req_i.task_id),
    .req_new_priority_i(req_i.new_priority),
    .req_slot_index_i  (req_i.slot_index),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_ok_o          (rsp_o.ok),
    .rsp_running_slot_o(rsp_o.running_slot),
    .rsp_running_id_o  (rsp_o.running_id),
    .rsp_switched_o    (rsp_o.switched),
    .rsp_task_count_o  (rsp_o.task_count),
    .rsp_read_id_o     (rsp_o.read_id),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

### rtl/apts_checker.sv
// apts_checker: port-level assertions for the task scheduler, with its bind
`timescale 1ns / 1ps

module apts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_ok_i,
  input logic [5:0]  rsp_running_slot_i,
  input logic [15:0] rsp_running_id_i,
  input logic        rsp_switched_i,
  input logic [6:0]  rsp_task_count_i,
  input logic [15:0] rsp_read_id_i
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_ok_i)
      && $stable(rsp_running_slot_i) && $stable(rsp_running_id_i)
      && $stable(rsp_switched_i) && $stable(rsp_task_count_i)
      && $stable(rsp_read_id_i))
    else $error("response changed while stalled");

  // a task switch only comes from a successful schedule
  a_switch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_switched_i |-> rsp_ok_i)
    else $error("switched without ok");

  // a nonzero read id only comes from a live slot
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_read_id_i != 16'd0) |-> rsp_ok_i)
    else $error("read id without ok");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

endmodule

bind aging_priority_task_scheduler apts_checker u_apts_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_ok_i          (rsp_o.ok),
  .rsp_running_slot_i(rsp_o.running_slot),
  .rsp_running_id_i  (rsp_o.running_id),
  .rsp_switched_i    (rsp_o.switched),
  .rsp_task_count_i  (rsp_o.task_count),
  .rsp_read_id_i     (rsp_o.read_id)
);

### sim/tb.sv
// tb: self-checking testbench of the aging priority task scheduler
`timescale 1ns / 1ps

module tb;
  import apts_pkg::*;

  localparam int TASK_SLOTS = 64;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] task_id;
    logic [15:0] new_priority;
    logic [5:0]  slot_index;
  } sched_req_t;

  typedef struct packed {
    logic        ok;
    logic [5:0]  running_slot;
    logic [15:0] running_id;
    logic        switched;
    logic [6:0]  task_count;
    logic [15:0] read_id;
  } sched_rsp_t;

  class sched_scoreboard;
    logic [15:0] prio_tbl [TASK_SLOTS];
    logic [15:0] id_tbl [TASK_SLOTS];
    int          live_tasks;
    int          run_slot;
    logic [15:0] last_id;
    sched_rsp_t  pending_rsp [$];
    int          mismatches;

    function new();
      foreach (prio_tbl[i]) begin
        prio_tbl[i] = '0;
        id_tbl[i] = '0;
      end
      prio_tbl[0] = SLOT0_PRIO;
      live_tasks = 1;
      run_slot = 0;
      last_id = '0;
      mismatches = 0;
    endfunction

    // remove one slot, shift the upper slots down, clear the vacated top and reset the running slot
    function void drop_slot(int pos);
      for (int i = pos; i + 1 < live_tasks; i++) begin
        prio_tbl[i] = prio_tbl[i + 1];
        id_tbl[i] = id_tbl[i + 1];
      end
      live_tasks--;
      prio_tbl[live_tasks] = '0;
      id_tbl[live_tasks] = '0;
      run_slot = 0;
    endfunction

    function void apply_request(sched_req_t r);
      sched_rsp_t  exp;
      int          pos;
      logic [15:0] best;
      exp = '0;
      case (r.action)
        ACT_SCHEDULE: begin
          if (live_tasks > 0) begin
            pos = 0;
            best = prio_tbl[0];
            for (int i = 1; i < live_tasks; i++) begin
              if (prio_tbl[i] > best) begin
                best = prio_tbl[i];
                pos = i;
              end
            end
            for (int i = 0; i < live_tasks; i++) begin
              if (prio_tbl[i] != PRIO_MAX) prio_tbl[i] = prio_tbl[i] + 16'd1;
            end
            prio_tbl[pos] = '0;
            run_slot = pos;
            exp.switched = (pos != 0);
            exp.ok = 1'b1;
          end
        end
        ACT_CREATE: begin
          if (live_tasks < TASK_SLOTS) begin
            last_id = last_id + 16'd1;
            id_tbl[live_tasks] = last_id;
            prio_tbl[live_tasks] = NEW_TASK_PRIO;
            live_tasks++;
            exp.ok = 1'b1;
          end
        end
        ACT_KILL: begin
          // slot 0 is never a kill target; the lowest matching slot goes
          pos = 0;
          for (int i = live_tasks - 1; i >= 1; i--) begin
            if (id_tbl[i] == r.task_id) pos = i;
          end
          if (pos != 0) begin
            drop_slot(pos);
            exp.ok = 1'b1;
          end
        end
        ACT_EXIT: begin
          if (run_slot < live_tasks) begin
            drop_slot(run_slot);
            exp.ok = 1'b1;
          end
        end
        ACT_SET_PRIO: begin
          if (run_slot < live_tasks) begin
            prio_tbl[run_slot] = r.new_priority;
            exp.ok = 1'b1;
          end
        end
        ACT_READ_COUNT: exp.ok = 1'b1;
        ACT_READ_ID: begin
          if (int'(r.slot_index) < live_tasks) begin
            exp.read_id = id_tbl[r.slot_index];
            exp.ok = 1'b1;
          end
        end
        default: ;
      endcase
      exp.running_slot = run_slot[5:0];
      exp.running_id = (run_slot < live_tasks) ? id_tbl[run_slot] : 16'd0;
      exp.task_count = live_tasks[6:0];
      pending_rsp.push_back(exp);
    endfunction

    function void report(string tag, sched_rsp_t exp, sched_rsp_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: exp ok=%0d slot=%0d id=%0d sw=%0d cnt=%0d rid=%0d", $time, tag,
                 exp.ok, exp.running_slot, exp.running_id, exp.switched, exp.task_count,
                 exp.read_id);
        $display("%0t %s: got ok=%0d slot=%0d id=%0d sw=%0d cnt=%0d rid=%0d", $time, tag,
                 got.ok, got.running_slot, got.running_id, got.switched, got.task_count,
                 got.read_id);
      end
    endfunction

    function void check_response(sched_rsp_t got);
      sched_rsp_t exp;
      if (pending_rsp.size() == 0) begin
        report("unexpected response", '0, got);
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.ok !== exp.ok || got.running_slot !== exp.running_slot ||
          got.running_id !== exp.running_id || got.switched !== exp.switched ||
          got.task_count !== exp.task_count || got.read_id !== exp.read_id)
        report("mismatch", exp, got);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  apts_req_if req_if ();
  apts_rsp_if rsp_if ();

  aging_priority_task_scheduler #(
    .MAX_TASKS(TASK_SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  sched_scoreboard sb = new();

  bit no_idle = 1'b0;
  int hold_request = 0;
  int n_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [15:0] live_id();
    if (sb.live_tasks == 0) return 16'($urandom);
    return sb.id_tbl[$urandom_range(0, sb.live_tasks - 1)];
  endfunction

  task automatic issue(input logic [2:0] act, input logic [15:0] id, input logic [15:0] prio,
                       input logic [5:0] idx);
    sched_req_t r;
    int         gap;
    r = '{act, id, prio, idx};
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.task_id <= id;
    req_if.new_priority <= prio;
    req_if.slot_index <= idx;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sb.apply_request(r);
    n_sent++;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // response side: random stalls, steady stretches and one long hold-off
  initial begin : rsp_side
    int         stall_left;
    int         steady_left;
    sched_rsp_t got;
    stall_left = 0;
    steady_left = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got = '{rsp_if.ok, rsp_if.running_slot, rsp_if.running_id, rsp_if.switched,
                rsp_if.task_count, rsp_if.read_id};
        sb.check_response(got);
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        steady_left = 0;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        rsp_if.ready <= 1'b1;
        steady_left--;
      end else begin
        case ($urandom_range(0, 9))
          0: steady_left = $urandom_range(30, 150);
          1, 2: stall_left = idle_len() + 1;
          default: ;
        endcase
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int         base;
    int         burst;
    int         burst_len;
    int         pick;
    bit         held;
    bit         paused;
    logic [2:0] act;
    logic [15:0] prio;
    logic [5:0] idx;
    held = 1'b0;
    paused = 1'b0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.action <= ACT_READ_COUNT;
    req_if.task_id <= '0;
    req_if.new_priority <= '0;
    req_if.slot_index <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads, single task, aging with a tie at saturation, removals down to empty
    issue(ACT_READ_COUNT, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_READ_ID, 16'hFFFF, 16'hFFFF, 6'd0);
    issue(ACT_READ_ID, 16'h0000, 16'h0000, 6'd63);
    issue(ACT_SCHEDULE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_CREATE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_CREATE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_CREATE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_SCHEDULE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_SET_PRIO, 16'h0000, 16'hFFFF, 6'd0);
    issue(ACT_KILL, 16'd3, 16'h0000, 6'd0);
    issue(ACT_SET_PRIO, 16'h0000, 16'hFFFF, 6'd0);
    issue(ACT_SCHEDULE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_KILL, 16'd0, 16'h0000, 6'd0);
    issue(ACT_KILL, 16'hFFFF, 16'h0000, 6'd0);
    issue(ACT_EXIT, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_READ_ID, 16'h0000, 16'h0000, 6'd1);
    issue(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 6'd63);
    issue(ACT_EXIT, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_EXIT, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_SCHEDULE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_EXIT, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_SET_PRIO, 16'h0000, 16'h1234, 6'd0);
    issue(ACT_READ_ID, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_CREATE, 16'h0000, 16'h0000, 6'd0);
    issue(ACT_READ_COUNT, 16'h0000, 16'h0000, 6'd0);

    base = n_sent;
    while (n_sent - base < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(0, 19);
      if (burst == 0) begin
        // fill the table and push past full
        burst_len = TASK_SLOTS - sb.live_tasks + $urandom_range(1, 3);
        repeat (burst_len) issue(ACT_CREATE, 16'($urandom), 16'($urandom), 6'($urandom));
      end else if (burst <= 2) begin
        burst_len = $urandom_range(1, sb.live_tasks + 1);
        repeat (burst_len) begin
          if ($urandom_range(0, 2) == 0)
            issue(ACT_EXIT, 16'($urandom), 16'($urandom), 6'($urandom));
          else
            issue(ACT_KILL, live_id(), 16'($urandom), 6'($urandom));
        end
      end else begin
        repeat (16) begin
          pick = $urandom_range(0, 99);
          act = (pick < 30) ? ACT_SCHEDULE : (pick < 45) ? ACT_CREATE :
                (pick < 60) ? ACT_KILL : (pick < 67) ? ACT_EXIT :
                (pick < 80) ? ACT_SET_PRIO : (pick < 85) ? ACT_READ_COUNT :
                (pick < 95) ? ACT_READ_ID : ACT_UNUSED;
          case ($urandom_range(0, 3))
            0: prio = PRIO_MAX;
            1: prio = 16'($urandom_range(0, 8));
            default: prio = 16'($urandom);
          endcase
          if ($urandom_range(0, 3) != 0 && sb.live_tasks > 0)
            idx = 6'($urandom_range(0, sb.live_tasks - 1));
          else
            idx = 6'($urandom_range(0, 63));
          issue(act, ($urandom_range(0, 3) != 0) ? live_id() : 16'($urandom), prio, idx);
        end
      end
      if (!held && n_sent - base >= RANDOM_ITEMS / 3) begin
        // receiver holds off while requests keep coming
        hold_request = HOLD_CYCLES;
        held = 1'b1;
      end
      if (!paused && n_sent - base >= 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
      $display("aging_priority_task_scheduler test passed");
    else
      $display("aging_priority_task_scheduler test failed");
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("aging_priority_task_scheduler test failed");
    $finish;
  end

endmodule

### files.f
rtl/apts_pkg.sv
rtl/apts_if.sv
rtl/apts_ctrl.sv
rtl/apts_datapath.sv
rtl/aging_priority_task_scheduler.sv
rtl/apts_checker.sv
sim/tb.sv
